### design/cud_pkg.sv
// Shared types and character constants for the C string unescape decoder.
package cud_pkg;

   localparam int unsigned FIFO_DEPTH = 4;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6e;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_V      = 8'h76;

   localparam logic [7:0] CODE_BEL = 8'd7;
   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_FF  = 8'd12;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_CR  = 8'd13;
   localparam logic [7:0] CODE_HT  = 8'd9;
   localparam logic [7:0] CODE_VT  = 8'd11;

   localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic       string_end;
      logic       bad_escape;
   } result_type;

   // Up to two results produced by one input transfer.
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

   typedef struct packed {
      logic       escape_pending;
      logic [1:0] octal_digits;
      logic [8:0] octal_accum;
      logic       error_sticky;
   } state_type;

endpackage

### design/c_string_unescape_decoder.sv
// Top level of the C string unescape decoder.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req_in_byte, req_in_last
//  rsp     | out | rsp_valid/rsp_ready  | rsp_out_byte, rsp_has_byte, rsp_run_last,
//          |     |                      | rsp_string_end, rsp_bad_escape
//
// One byte is taken per cycle while req_ready is high; its 0, 1 or 2 results land
// in the result queue at that same edge and the first can transfer on the next cycle.
// Throughput is set by the result queue draining one result per cycle while rsp_ready
// is high: the second result of a byte that gives two results is absorbed by the queue.
// req_ready is high while the queue has room for two results, so a stall on
// rsp backs up into req once more than FIFO_DEPTH-2 results are queued.
// Synchronous active-high reset clears the decoder state and empties the queue.
module c_string_unescape_decoder #(
   parameter int unsigned FIFO_DEPTH = cud_pkg::FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end,
   output logic       rsp_bad_escape
);

   cud_pkg::push_type   push;
   cud_pkg::result_type head;
   logic                accept;
   logic                space_ok;

   // req is ready whenever the queue can take a worst-case byte
   assign req_ready = space_ok;
   assign accept    = req_valid && req_ready;

   cud_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .push    (push)
   );

   cud_result_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_has_byte   = head.has_byte;
   assign rsp_run_last   = head.run_last;
   assign rsp_string_end = head.string_end;
   assign rsp_bad_escape = head.bad_escape;

`ifndef ASSERT_OFF
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end without run last");
   a_nobyte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_out_byte == 8'd0)
      else $error("byte data without has_byte");
   a_bad_nobyte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_escape |-> !rsp_has_byte)
      else $error("bad escape carries a byte");
`endif

endmodule

### design/cud_decode.sv
// Escape decoder: state registers and per-byte result generation.
module cud_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output cud_pkg::push_type push
);

   cud_pkg::state_type  state_ff;
   cud_pkg::state_type  state_in;
   cud_pkg::result_type res [2];
   logic [1:0]          n;
   logic                is_oct;

   always_comb begin
      state_in = state_ff;
      n        = 2'd0;
      res[0]   = '0;
      res[1]   = '0;
      is_oct   = (in_byte >= cud_pkg::CHAR_ZERO) && (in_byte <= cud_pkg::CHAR_SEVEN);

      if (state_ff.error_sticky) begin
         if (in_last) begin
            res[0].bad_escape = 1'b1;
            n = 2'd1;
         end
      end else if (state_ff.escape_pending) begin
         state_in.escape_pending = 1'b0;
         n = 2'd1;
         res[0].has_byte = 1'b1;
         case (in_byte)
            cud_pkg::CHAR_QUOTE,
            cud_pkg::CHAR_BSLASH: res[0].out_byte = in_byte;
            cud_pkg::CHAR_A:      res[0].out_byte = cud_pkg::CODE_BEL;
            cud_pkg::CHAR_B:      res[0].out_byte = cud_pkg::CODE_BS;
            cud_pkg::CHAR_F:      res[0].out_byte = cud_pkg::CODE_FF;
            cud_pkg::CHAR_N:      res[0].out_byte = cud_pkg::CODE_LF;
            cud_pkg::CHAR_R:      res[0].out_byte = cud_pkg::CODE_CR;
            cud_pkg::CHAR_T:      res[0].out_byte = cud_pkg::CODE_HT;
            cud_pkg::CHAR_V:      res[0].out_byte = cud_pkg::CODE_VT;
            default: begin
               res[0].has_byte = 1'b0;
               if (is_oct) begin
                  n = 2'd0;
                  state_in.octal_digits = 2'd1;
                  state_in.octal_accum  = {6'd0, in_byte[2:0]};
               end else begin
                  state_in.error_sticky = 1'b1;
                  res[0].bad_escape     = 1'b1;
               end
            end
         endcase
      end else begin
         if ((state_ff.octal_digits != 2'd0) &&
             (state_ff.octal_digits < cud_pkg::OCTAL_MAX_DIGITS) && is_oct) begin
            // digit absorbed into the running octal value
            state_in.octal_digits = state_ff.octal_digits + 2'd1;
            state_in.octal_accum  = {state_ff.octal_accum[5:0], in_byte[2:0]};
         end else begin
            if (state_ff.octal_digits != 2'd0) begin
               res[0].out_byte = state_ff.octal_accum[7:0];
               res[0].has_byte = 1'b1;
               n = 2'd1;
               state_in.octal_digits = 2'd0;
               state_in.octal_accum  = '0;
            end
            if (in_byte == cud_pkg::CHAR_BSLASH) begin
               state_in.escape_pending = 1'b1;
            end else if (in_byte != cud_pkg::CHAR_QUOTE) begin
               res[n[0]].out_byte = in_byte;
               res[n[0]].has_byte = 1'b1;
               n = n + 2'd1;
            end
         end
      end

      if (in_last) begin
         if (!state_in.error_sticky && (state_in.octal_digits != 2'd0)) begin
            res[n[0]].out_byte = state_in.octal_accum[7:0];
            res[n[0]].has_byte = 1'b1;
            n = n + 2'd1;
         end
         if (n == 2'd0) begin
            n = 2'd1;
         end
         res[n[1]].string_end = 1'b1;
         state_in = '0;
      end
      if (n != 2'd0) begin
         res[n[1]].run_last = 1'b1;
      end

      push.count = accept ? n : 2'd0;
      push.r0    = res[0];
      push.r1    = res[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> state_ff == '0)
      else $error("state not cleared after string end");
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |-> push.count != 2'd0)
      else $error("string end produced no result");
   a_err_no_octal: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_sticky |-> !state_ff.escape_pending && state_ff.octal_digits == 2'd0)
      else $error("error state with pending escape or octal run");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two results from one byte");
`endif

endmodule

### design/cud_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module cud_result_fifo #(
   parameter int unsigned DEPTH = cud_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  cud_pkg::push_type   push,
   output logic                space_ok,
   output logic                out_valid,
   input  logic                out_ready,
   output cud_pkg::result_type out_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cud_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      out_valid = count_ff != '0;
      pop       = out_valid && out_ready;
      wr_next   = ptr_inc(wr_ff);
      wr_in     = (push.count == 2'd2) ? ptr_inc(wr_next) :
                  (push.count == 2'd1) ? wr_next : wr_ff;
      rd_in     = pop ? ptr_inc(rd_ff) : rd_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
      out_data  = mem_ff[rd_ff];
      space_ok  = count_ff <= CNT_W'(DEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");
   a_push_needs_space: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok)
      else $error("push without room");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0) && !pop |=> $stable(count_ff))
      else $error("count moved without push or pop");
`endif

endmodule
